FILE: rtl/rtpu_pkg.sv
// Package for the ringtone text parser: payload structs, codes, tone table.
// Used by every module of the block; depends on nothing.
package rtpu_pkg;

   typedef struct packed {
      logic [7:0] character;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [11:0] frequency_hz;
      logic [15:0] pwm_period;
      logic [15:0] pulse_us;
      logic [18:0] on_ms;
      logic [18:0] off_ms;
      logic        last;
   } rsp_type;

   localparam logic [1:0] STATUS_NOTE   = 2'd0;
   localparam logic [1:0] STATUS_END    = 2'd1;
   localparam logic [1:0] STATUS_HEADER = 2'd2;

   localparam logic [1:0] SUFFIX_NONE     = 2'd0;
   localparam logic [1:0] SUFFIX_LEGATO   = 2'd1;
   localparam logic [1:0] SUFFIX_STACCATO = 2'd2;

   // One note job handed from the parser to the timing engine.
   typedef struct packed {
      logic [1:0]  status;
      logic        last;
      logic        rest;
      logic        dot;
      logic [1:0]  suffix;
      logic [7:0]  beat;
      logic [11:0] freq;
      logic [15:0] tempo;
   } job_type;

   function automatic logic [11:0] tone_lookup(input logic [2:0] oct, input logic [3:0] idx);
      logic [11:0] r;
      logic [3:0]  i;
      i = (idx > 4'd13) ? 4'd13 : idx;
      r = 12'd0;
      case ({oct, i})
         {3'd0,4'd0}: r=27;   {3'd0,4'd1}: r=29;   {3'd0,4'd2}: r=31;   {3'd0,4'd3}: r=16;
         {3'd0,4'd4}: r=16;   {3'd0,4'd5}: r=17;   {3'd0,4'd6}: r=18;   {3'd0,4'd7}: r=19;
         {3'd0,4'd8}: r=20;   {3'd0,4'd9}: r=22;   {3'd0,4'd10}: r=22;  {3'd0,4'd11}: r=23;
         {3'd0,4'd12}: r=24;  {3'd0,4'd13}: r=26;
         {3'd1,4'd0}: r=55;   {3'd1,4'd1}: r=58;   {3'd1,4'd2}: r=62;   {3'd1,4'd3}: r=32;
         {3'd1,4'd4}: r=32;   {3'd1,4'd5}: r=34;   {3'd1,4'd6}: r=37;   {3'd1,4'd7}: r=39;
         {3'd1,4'd8}: r=41;   {3'd1,4'd9}: r=43;   {3'd1,4'd10}: r=43;  {3'd1,4'd11}: r=46;
         {3'd1,4'd12}: r=49;  {3'd1,4'd13}: r=52;
         {3'd2,4'd0}: r=110;  {3'd2,4'd1}: r=116;  {3'd2,4'd2}: r=123;  {3'd2,4'd3}: r=65;
         {3'd2,4'd4}: r=65;   {3'd2,4'd5}: r=69;   {3'd2,4'd6}: r=73;   {3'd2,4'd7}: r=78;
         {3'd2,4'd8}: r=82;   {3'd2,4'd9}: r=87;   {3'd2,4'd10}: r=87;  {3'd2,4'd11}: r=92;
         {3'd2,4'd12}: r=98;  {3'd2,4'd13}: r=103;
         {3'd3,4'd0}: r=220;  {3'd3,4'd1}: r=233;  {3'd3,4'd2}: r=247;  {3'd3,4'd3}: r=130;
         {3'd3,4'd4}: r=130;  {3'd3,4'd5}: r=138;  {3'd3,4'd6}: r=147;  {3'd3,4'd7}: r=155;
         {3'd3,4'd8}: r=164;  {3'd3,4'd9}: r=174;  {3'd3,4'd10}: r=174; {3'd3,4'd11}: r=185;
         {3'd3,4'd12}: r=196; {3'd3,4'd13}: r=207;
         {3'd4,4'd0}: r=440;  {3'd4,4'd1}: r=466;  {3'd4,4'd2}: r=494;  {3'd4,4'd3}: r=261;
         {3'd4,4'd4}: r=261;  {3'd4,4'd5}: r=277;  {3'd4,4'd6}: r=294;  {3'd4,4'd7}: r=311;
         {3'd4,4'd8}: r=329;  {3'd4,4'd9}: r=349;  {3'd4,4'd10}: r=349; {3'd4,4'd11}: r=370;
         {3'd4,4'd12}: r=392; {3'd4,4'd13}: r=415;
         {3'd5,4'd0}: r=880;  {3'd5,4'd1}: r=932;  {3'd5,4'd2}: r=988;  {3'd5,4'd3}: r=523;
         {3'd5,4'd4}: r=523;  {3'd5,4'd5}: r=554;  {3'd5,4'd6}: r=587;  {3'd5,4'd7}: r=622;
         {3'd5,4'd8}: r=659;  {3'd5,4'd9}: r=698;  {3'd5,4'd10}: r=698; {3'd5,4'd11}: r=740;
         {3'd5,4'd12}: r=784; {3'd5,4'd13}: r=830;
         {3'd6,4'd0}: r=1760; {3'd6,4'd1}: r=1865; {3'd6,4'd2}: r=1976; {3'd6,4'd3}: r=1047;
         {3'd6,4'd4}: r=1047; {3'd6,4'd5}: r=1109; {3'd6,4'd6}: r=1175; {3'd6,4'd7}: r=1245;
         {3'd6,4'd8}: r=1319; {3'd6,4'd9}: r=1319; {3'd6,4'd10}: r=1397; {3'd6,4'd11}: r=1480;
         {3'd6,4'd12}: r=1568; {3'd6,4'd13}: r=1661;
         {3'd7,4'd0}: r=3520; {3'd7,4'd1}: r=3729; {3'd7,4'd2}: r=3951; {3'd7,4'd3}: r=2093;
         {3'd7,4'd4}: r=2093; {3'd7,4'd5}: r=2217; {3'd7,4'd6}: r=2349; {3'd7,4'd7}: r=2489;
         {3'd7,4'd8}: r=2637; {3'd7,4'd9}: r=2637; {3'd7,4'd10}: r=2794; {3'd7,4'd11}: r=2960;
         {3'd7,4'd12}: r=3136; {3'd7,4'd13}: r=3322;
         default: r = 12'd0;
      endcase
      return r;
   endfunction

endpackage

FILE: rtl/ringtone_text_note_parser_unit.sv
// Top level of the ringtone text parser: parser, job queue and timing engine.
// Depends on rtpu_pkg, rtpu_parser, rtpu_queue and rtpu_timer.
//
// The block takes ringtone text one request per character. Header and note
// characters are parsed as they are taken, and the input stalls while the job
// queue is full; a note end, a comma or the end of text hands a job to a
// two-entry queue, so parsing of the next note goes on while the back end
// works. The back end runs the three divisions by beat, tempo and frequency
// through one shared 20-step bit-serial divider, each with its start and
// finish handoff; the tenth of the period, the volume scaling and the off-time
// tenth are short reciprocal multiplications. A rest skips the frequency
// division and the pulse steps, a plain note needs the extra off-time step, and
// a status-only result skips the back end's work. Volume must be written
// through the csr port only while the block is idle; the block does not
// enforce this. Volume is clamped to 1..100.
module ringtone_text_note_parser_unit import rtpu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data,
   input  logic    csr_valid,
   output logic    csr_ready,
   input  logic [6:0] csr_data
);

   logic [6:0] volume_ff;
   logic       push_valid, push_ready, pop_valid, pop_ready;
   job_type    push_data, pop_data;

   assign csr_ready = 1'b1;

   // Volume is held clamped so the back end never sees an out-of-range value.
   always_ff @(posedge clock) begin
      if (reset) begin
         volume_ff <= 7'd100;
      end else if (csr_valid) begin
         volume_ff <= (csr_data == 7'd0) ? 7'd1 : ((csr_data > 7'd100) ? 7'd100 : csr_data);
      end
   end

   rtpu_parser u_parser (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_ready(req_ready),
      .in_data(req_data), .job_valid(push_valid), .job_ready(push_ready),
      .job_data(push_data)
   );

   rtpu_queue u_queue (
      .clock(clock), .reset(reset), .push_valid(push_valid), .push_ready(push_ready),
      .push_data(push_data), .pop_valid(pop_valid), .pop_ready(pop_ready),
      .pop_data(pop_data)
   );

   rtpu_timer u_timer (
      .clock(clock), .reset(reset), .volume(volume_ff), .job_valid(pop_valid),
      .job_ready(pop_ready), .job_data(pop_data), .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

endmodule

FILE: rtl/rtpu_parser.sv
// Front end: parses characters to jobs, one per cycle unless the queue is full.
// Depends on rtpu_pkg.
module rtpu_parser import rtpu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_data,
   output logic    job_valid,
   input  logic    job_ready,
   output job_type job_data
);

   typedef enum logic [3:0] {
      PH_NAME, PH_NAME_VAL, PH_KEYS, PH_KEYS_VAL, PH_BEAT, PH_ACC, PH_OCT,
      PH_DOT, PH_SUF, PH_TAIL, PH_SKIP
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [7:0]  dbeat_ff, dbeat_in;
   logic [2:0]  doct_ff, doct_in;
   logic [15:0] tempo_ff, tempo_in;
   logic [7:0]  key_ff, key_in;
   logic [15:0] acc_ff, acc_in;
   logic [7:0]  nbeat_ff, nbeat_in;
   logic [3:0]  nidx_ff, nidx_in;
   logic [2:0]  noct_ff, noct_in;
   logic        rest_ff, rest_in, dot_ff, dot_in;
   logic [1:0]  suf_ff, suf_in;

   logic        emit;
   job_type     job;
   logic [7:0]  c, lc;
   logic        digit;
   logic [19:0] acc_next;
   logic [2:0]  oct_sel;

   // A job is only pushed when the queue has room; a stall holds the input.
   assign in_ready  = job_ready;
   assign job_valid = in_valid && emit;
   assign job_data  = job;
   assign c     = in_data.character;
   assign lc    = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
   assign digit = (c >= "0" && c <= "9");
   assign acc_next = ({4'd0, acc_ff} * 20'd10) + {16'd0, c[3:0]};

   always_comb begin
      phase_type ph;
      logic      done;
      logic [15:0] v;
      phase_in = phase_ff; dbeat_in = dbeat_ff; doct_in = doct_ff; tempo_in = tempo_ff;
      key_in = key_ff; acc_in = acc_ff; nbeat_in = nbeat_ff; nidx_in = nidx_ff;
      noct_in = noct_ff; rest_in = rest_ff; dot_in = dot_ff; suf_in = suf_ff;
      emit = 1'b0; done = 1'b0; ph = phase_ff; v = acc_ff;
      oct_sel = doct_ff;
      job = '0;
      if (phase_ff < PH_BEAT) begin
         if ((phase_ff == PH_NAME_VAL || phase_ff == PH_KEYS_VAL) && digit) begin
            acc_in = (acc_next > 20'd65535) ? 16'hFFFF : acc_next[15:0];
         end else begin
            ph = phase_ff;
            if (phase_ff == PH_NAME_VAL || phase_ff == PH_KEYS_VAL) begin
               if (v != 16'd0) begin
                  if (key_ff == "d") dbeat_in = (v > 16'd255) ? 8'd255 : v[7:0];
                  else if (key_ff == "o") doct_in = (v > 16'd7) ? 3'd7 : v[2:0];
                  else if (key_ff == "b") tempo_in = v;
               end
               key_in = 8'd0; acc_in = 16'd0;
               ph = (phase_ff == PH_NAME_VAL) ? PH_NAME : PH_KEYS;
            end
            if (c == "=") begin
               acc_in = 16'd0;
               ph = (ph == PH_NAME) ? PH_NAME_VAL : PH_KEYS_VAL;
            end else if (c == ":") begin
               key_in = 8'd0;
               if (ph == PH_NAME) begin
                  ph = PH_KEYS;
               end else begin
                  ph = PH_BEAT;
                  acc_in = 16'd0; nbeat_in = 8'd0; nidx_in = 4'd0; noct_in = 3'd0;
                  rest_in = 1'b0; dot_in = 1'b0; suf_in = SUFFIX_NONE;
               end
            end else begin
               key_in = c;
            end
            phase_in = ph;
         end
         if (in_data.end_of_text && phase_in < PH_BEAT) begin
            emit = 1'b1;
            job.status = STATUS_HEADER;
            job.last = 1'b1;
         end
      end else if (c == ",") begin
         done = 1'b1;
      end else begin
         if (ph == PH_BEAT) begin
            if (digit) begin
               acc_in = (acc_next > 20'd65535) ? 16'hFFFF : acc_next[15:0];
            end else begin
               nbeat_in = (acc_ff == 16'd0) ? dbeat_ff :
                          ((acc_ff > 16'd255) ? 8'd255 : acc_ff[7:0]);
               if (c == "p") begin
                  rest_in = 1'b1; phase_in = PH_DOT;
               end else if (lc >= "a" && lc <= "g") begin
                  nidx_in = {lc[2:0] - 3'd1, 1'b0}; phase_in = PH_ACC;
               end else begin
                  phase_in = PH_SKIP;
               end
            end
         end else begin
            if (ph == PH_ACC) begin
               if (c == "#") begin
                  nidx_in = nidx_ff + 4'd1; phase_in = PH_OCT; ph = PH_SKIP;
               end else if (c == "b") begin
                  nidx_in = (nidx_ff == 4'd0) ? 4'd13 : nidx_ff - 4'd1;
                  phase_in = PH_OCT; ph = PH_SKIP;
               end else begin
                  ph = PH_OCT;
               end
            end
            if (ph == PH_OCT) begin
               if (digit) begin
                  noct_in = (c[3:0] > 4'd7) ? 3'd7 : c[2:0];
                  phase_in = PH_DOT; ph = PH_SKIP;
               end else begin
                  ph = PH_DOT;
               end
            end
            if (ph == PH_DOT) begin
               if (c == ".") begin
                  dot_in = 1'b1; phase_in = PH_SUF; ph = PH_SKIP;
               end else begin
                  ph = PH_SUF;
               end
            end
            if (ph == PH_SUF) begin
               if (c == "l") suf_in = SUFFIX_LEGATO;
               else if (c == "s") suf_in = SUFFIX_STACCATO;
               phase_in = PH_TAIL;
            end
         end
      end
      // The closing colon and the end mark may arrive on the same character,
      // so the note section is judged by the phase after this character.
      if (phase_in >= PH_BEAT && (done || in_data.end_of_text)) begin
         if (phase_in >= PH_ACC && phase_in <= PH_TAIL) begin
            emit = 1'b1;
            job.status = STATUS_NOTE;
            job.last = in_data.end_of_text;
            job.rest = rest_in;
            job.dot = dot_in;
            job.suffix = suf_in;
            job.beat = nbeat_in;
            job.tempo = tempo_in;
            oct_sel = (noct_in != 3'd0) ? noct_in : doct_in;
            job.freq = rest_in ? 12'd0 : tone_lookup(oct_sel, nidx_in);
         end else if (in_data.end_of_text) begin
            emit = 1'b1;
            job.status = STATUS_END;
            job.last = 1'b1;
         end
         phase_in = PH_BEAT;
         acc_in = 16'd0; nbeat_in = 8'd0; nidx_in = 4'd0; noct_in = 3'd0;
         rest_in = 1'b0; dot_in = 1'b0; suf_in = SUFFIX_NONE;
      end
      if (in_data.end_of_text) begin
         phase_in = PH_NAME; key_in = 8'd0;
         acc_in = 16'd0; nbeat_in = 8'd0; nidx_in = 4'd0; noct_in = 3'd0;
         rest_in = 1'b0; dot_in = 1'b0; suf_in = SUFFIX_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_NAME; dbeat_ff <= 8'd8; doct_ff <= 3'd6; tempo_ff <= 16'd120;
         key_ff <= 8'd0; acc_ff <= 16'd0; nbeat_ff <= 8'd0; nidx_ff <= 4'd0;
         noct_ff <= 3'd0; rest_ff <= 1'b0; dot_ff <= 1'b0; suf_ff <= SUFFIX_NONE;
      end else if (in_valid && in_ready) begin
         phase_ff <= phase_in; dbeat_ff <= dbeat_in; doct_ff <= doct_in;
         tempo_ff <= tempo_in; key_ff <= key_in; acc_ff <= acc_in;
         nbeat_ff <= nbeat_in; nidx_ff <= nidx_in; noct_ff <= noct_in;
         rest_ff <= rest_in; dot_ff <= dot_in; suf_ff <= suf_in;
      end
   end

endmodule

FILE: rtl/rtpu_queue.sv
// Two-entry job queue between the parser and the timing engine.
// Depends on rtpu_pkg.
module rtpu_queue import rtpu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_data
);

   job_type    mem_ff [2];
   logic       wptr_ff, rptr_ff;
   logic [1:0] count_ff;
   logic       do_push, do_pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_data   = mem_ff[rptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0; rptr_ff <= 1'b0; count_ff <= 2'd0;
      end else begin
         if (do_push) wptr_ff <= ~wptr_ff;
         if (do_pop) rptr_ff <= ~rptr_ff;
         count_ff <= count_ff + {1'b0, do_push} - {1'b0, do_pop};
      end
   end

endmodule

FILE: rtl/rtpu_divider.sv
// Shared radix-2 restoring divider, 20-bit dividend by 16-bit divisor.
// Depends on rtpu_pkg.
module rtpu_divider import rtpu_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [19:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [19:0] quotient
);

   logic [19:0] quo_ff;
   logic [16:0] rem_ff;
   logic [15:0] dvs_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [16:0] trial;
   logic [16:0] sub;

   assign trial = {rem_ff[15:0], quo_ff[19]};
   assign sub = trial - {1'b0, dvs_ff};
   assign done = done_ff;
   assign quotient = quo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0; cnt_ff <= 5'd0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1; cnt_ff <= 5'd0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd19) begin
               busy_ff <= 1'b0; done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend; rem_ff <= 17'd0; dvs_ff <= divisor;
      end else if (busy_ff) begin
         if (!sub[16]) begin
            rem_ff <= sub; quo_ff <= {quo_ff[18:0], 1'b1};
         end else begin
            rem_ff <= trial; quo_ff <= {quo_ff[18:0], 1'b0};
         end
      end
   end

endmodule

FILE: rtl/rtpu_timer.sv
// Back end: turns a note job into frequency, PWM and on/off times; status jobs pass straight to the result.
// Depends on rtpu_pkg and rtpu_divider.
module rtpu_timer import rtpu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic [6:0] volume,
   input  logic    job_valid,
   output logic    job_ready,
   input  job_type job_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_DUR, S_TEMPO, S_PERIOD, S_TENTH, S_VOL, S_HUND, S_MS, S_SPLIT, S_OUT
   } state_type;

   // Reciprocals for the constant divisors; each is exact over its operand range.
   localparam logic [31:0] RECIP_TENTH16   = 32'd52429;     // 2^19 / 10, 16-bit operand
   localparam logic [39:0] RECIP_TENTH19   = 40'd838861;    // 2^23 / 10, 19-bit operand
   localparam logic [47:0] RECIP_HUNDREDTH = 48'd10737419;  // 2^30 / 100, 23-bit operand

   state_type   state_ff;
   job_type     job_ff;
   logic [7:0]  dur_ff;
   logic [15:0] period_ff;
   logic [19:0] tmp_ff;
   logic [23:0] scale_ff;
   rsp_type     rsp_ff;
   logic        div_start_ff;
   logic [19:0] div_a_ff;
   logic [15:0] div_b_ff;
   logic        div_done;
   logic [19:0] div_q;
   logic [18:0] dur_ms;
   logic [31:0] tenth_prod;
   logic [47:0] hund_prod;
   logic [39:0] split_prod;

   rtpu_divider u_div (
      .clock(clock), .reset(reset), .start(div_start_ff), .dividend(div_a_ff),
      .divisor(div_b_ff), .done(div_done), .quotient(div_q)
   );

   assign job_ready  = (state_ff == S_IDLE) && !rsp_valid;
   assign rsp_valid  = (state_ff == S_OUT);
   assign rsp_data   = rsp_ff;
   assign dur_ms     = {8'd0, tmp_ff[10:0]} * {11'd0, dur_ff};
   assign tenth_prod = {16'd0, period_ff} * RECIP_TENTH16;
   assign hund_prod  = {24'd0, scale_ff} * RECIP_HUNDREDTH;
   assign split_prod = {21'd0, dur_ms} * RECIP_TENTH19;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; div_start_ff <= 1'b0;
      end else begin
         div_start_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (job_valid) begin
                  job_ff <= job_data;
                  rsp_ff <= '{status: job_data.status, last: job_data.last, default: '0};
                  if (job_data.status == STATUS_NOTE) begin
                     div_a_ff <= 20'd128;
                     div_b_ff <= (job_data.beat == 8'd0) ? 16'd1 : {8'd0, job_data.beat};
                     div_start_ff <= 1'b1;
                     state_ff <= S_DUR;
                  end else begin
                     state_ff <= S_OUT;
                  end
               end
            end
            S_DUR: begin
               if (div_done) begin
                  dur_ff <= job_ff.dot ? (div_q[7:0] + {1'b0, div_q[7:1]}) : div_q[7:0];
                  div_a_ff <= 20'd60000;
                  div_b_ff <= (job_ff.tempo == 16'd0) ? 16'd1 : job_ff.tempo;
                  div_start_ff <= 1'b1;
                  state_ff <= S_TEMPO;
               end
            end
            S_TEMPO: begin
               if (div_done) begin
                  tmp_ff <= {5'd0, div_q[19:5]};
                  if (job_ff.rest) begin
                     state_ff <= S_MS;
                  end else begin
                     div_a_ff <= 20'd1000000;
                     div_b_ff <= {4'd0, job_ff.freq};
                     div_start_ff <= 1'b1;
                     state_ff <= S_PERIOD;
                  end
               end
            end
            S_PERIOD: begin
               if (div_done) begin
                  period_ff <= div_q[15:0];
                  rsp_ff.frequency_hz <= job_ff.freq;
                  rsp_ff.pwm_period <= div_q[15:0];
                  state_ff <= S_TENTH;
               end
            end
            S_TENTH: begin
               // Ninety percent of the period.
               scale_ff <= {8'd0, period_ff - {3'd0, tenth_prod[31:19]}};
               state_ff <= S_VOL;
            end
            S_VOL: begin
               scale_ff <= {8'd0, scale_ff[15:0]} * {17'd0, volume};
               state_ff <= S_HUND;
            end
            S_HUND: begin
               rsp_ff.pulse_us <= hund_prod[45:30];
               state_ff <= S_MS;
            end
            S_MS: begin
               if (job_ff.rest) begin
                  rsp_ff.off_ms <= dur_ms;
                  state_ff <= S_OUT;
               end else if (job_ff.suffix == SUFFIX_LEGATO) begin
                  rsp_ff.on_ms <= dur_ms;
                  state_ff <= S_OUT;
               end else if (job_ff.suffix == SUFFIX_STACCATO) begin
                  rsp_ff.off_ms <= {1'b0, dur_ms[18:1]};
                  rsp_ff.on_ms <= dur_ms - {1'b0, dur_ms[18:1]};
                  state_ff <= S_OUT;
               end else begin
                  rsp_ff.off_ms <= {3'd0, split_prod[38:23]};
                  state_ff <= S_SPLIT;
               end
            end
            S_SPLIT: begin
               rsp_ff.on_ms <= dur_ms - rsp_ff.off_ms;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (rsp_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

FILE: rtl/rtpu_checker.sv
// Port-level checker for the ringtone text parser, bound to the top level.
// Depends on rtpu_pkg.
module rtpu_checker import rtpu_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A stalled result keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // Status codes outside the three defined ones never appear.
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == STATUS_NOTE || rsp_data.status == STATUS_END ||
                     rsp_data.status == STATUS_HEADER))
      else $error("bad status");

   // Non-note results carry no timing and always end the tune.
   a_end_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != STATUS_NOTE |->
      rsp_data.last && rsp_data.frequency_hz == 12'd0 && rsp_data.on_ms == 19'd0)
      else $error("status result with payload");

   // A rest has no period and no pulse.
   a_rest: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frequency_hz == 12'd0 |->
      rsp_data.pwm_period == 16'd0 && rsp_data.pulse_us == 16'd0)
      else $error("rest with pulse");

endmodule

bind ringtone_text_note_parser_unit rtpu_checker u_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);

FILE: tb/tb_top.sv
// Self-checking testbench for ringtone_text_note_parser_unit: feeds ringtone text one
// request per character, predicts every note result and compares them field by field.
// Depends on rtpu_pkg and the RTL of the block.
module tb_top;
   import rtpu_pkg::*;

   // Parser phases of the predictor, in the order the text walks through them.
   localparam int PH_NAME = 0, PH_NAME_VAL = 1, PH_KEYS = 2, PH_KEYS_VAL = 3;
   localparam int PH_BEAT = 4, PH_ACC = 5, PH_OCT = 6, PH_DOT = 7;
   localparam int PH_SUF = 8, PH_TAIL = 9, PH_SKIP = 10;
   localparam int FLAG_REST = 1, FLAG_DOT = 2;

   // Frequency by octave and semitone slot (slots run a, a#, b, b#/c, c, c#, ... g#).
   localparam int TONES [8][14] = '{
      '{27, 29, 31, 16, 16, 17, 18, 19, 20, 22, 22, 23, 24, 26},
      '{55, 58, 62, 32, 32, 34, 37, 39, 41, 43, 43, 46, 49, 52},
      '{110, 116, 123, 65, 65, 69, 73, 78, 82, 87, 87, 92, 98, 103},
      '{220, 233, 247, 130, 130, 138, 147, 155, 164, 174, 174, 185, 196, 207},
      '{440, 466, 494, 261, 261, 277, 294, 311, 329, 349, 349, 370, 392, 415},
      '{880, 932, 988, 523, 523, 554, 587, 622, 659, 698, 698, 740, 784, 830},
      '{1760, 1865, 1976, 1047, 1047, 1109, 1175, 1245, 1319, 1319, 1397, 1480,
        1568, 1661},
      '{3520, 3729, 3951, 2093, 2093, 2217, 2349, 2489, 2637, 2637, 2794, 2960,
        3136, 3322}};

   // The scoreboard mirrors the parser state, turns every accepted character into
   // the note result it causes, if any, and matches results in order.
   class note_scoreboard;
      int unsigned volume, phase, dflt_beat, dflt_oct, tempo, key, acc;
      int unsigned nbeat, nidx, noct, nflags, suffix;
      rsp_type     expected_notes[$];
      int          errors;

      function new();
         volume = 100; phase = PH_NAME; dflt_beat = 8; dflt_oct = 6; tempo = 120;
         key = 0; errors = 0;
         clear_note();
      endfunction

      function void set_volume(logic [6:0] v);
         volume = (v < 1) ? 1 : ((v > 100) ? 100 : v);
      endfunction

      function void clear_note();
         acc = 0; nbeat = 0; nidx = 0; noct = 0; nflags = 0; suffix = SUFFIX_NONE;
      endfunction

      function void add_digit(byte unsigned c);
         int unsigned v;
         v = acc * 10 + (c - "0");
         acc = (v > 65535) ? 65535 : v;
      endfunction

      function bit is_digit(byte unsigned c);
         return c >= "0" && c <= "9";
      endfunction

      function void header_char(byte unsigned c);
         if (phase == PH_NAME_VAL || phase == PH_KEYS_VAL) begin
            if (is_digit(c)) begin
               add_digit(c);
               return;
            end
            // A zero value leaves the setting alone.
            if (acc != 0) begin
               if (key == "d") dflt_beat = (acc > 255) ? 255 : acc;
               else if (key == "o") dflt_oct = (acc > 7) ? 7 : acc;
               else if (key == "b") tempo = acc;
            end
            key = 0; acc = 0;
            phase = phase - 1;
         end
         if (c == "=") begin
            acc = 0;
            phase = phase + 1;
         end else if (c == ":") begin
            key = 0;
            if (phase == PH_NAME) phase = PH_KEYS;
            else begin
               phase = PH_BEAT;
               clear_note();
            end
         end else begin
            key = c;
         end
      endfunction

      function void note_char(byte unsigned c);
         int unsigned p, lc, d;
         p = phase;
         if (p == PH_BEAT) begin
            lc = (c >= "A" && c <= "Z") ? (c | 8'h20) : c;
            if (is_digit(c)) begin
               add_digit(c);
               return;
            end
            nbeat = (acc == 0) ? dflt_beat : ((acc > 255) ? 255 : acc);
            if (c == "p") begin
               nflags = FLAG_REST;
               phase = PH_DOT;
            end else if (lc >= "a" && lc <= "g") begin
               nidx = (lc - "a") * 2;
               phase = PH_ACC;
            end else begin
               phase = PH_SKIP;
            end
            return;
         end
         if (p == PH_ACC) begin
            if (c == "#") begin
               nidx++; phase = PH_OCT;
               return;
            end
            if (c == "b") begin
               // Flat of a wraps round to g sharp.
               nidx = (nidx == 0) ? 13 : nidx - 1; phase = PH_OCT;
               return;
            end
            p = PH_OCT;
         end
         if (p == PH_OCT) begin
            if (is_digit(c)) begin
               d = c - "0";
               noct = (d > 7) ? 7 : d;
               phase = PH_DOT;
               return;
            end
            p = PH_DOT;
         end
         if (p == PH_DOT) begin
            if (c == ".") begin
               nflags |= FLAG_DOT; phase = PH_SUF;
               return;
            end
            p = PH_SUF;
         end
         if (p == PH_SUF) begin
            if (c == "l") suffix = SUFFIX_LEGATO;
            else if (c == "s") suffix = SUFFIX_STACCATO;
            phase = PH_TAIL;
         end
      endfunction

      function rsp_type timed_note();
         rsp_type     r;
         int unsigned b, t, dur, dms, octv, idx, f, per, on, off;
         r = '0;
         b = (nbeat == 0) ? 1 : nbeat;
         t = (tempo == 0) ? 1 : tempo;
         dur = 128 / b;
         if (nflags & FLAG_DOT) dur += dur / 2;
         dms = (60000 / t / 32) * dur;
         if (!(nflags & FLAG_REST)) begin
            octv = (noct != 0) ? noct : dflt_oct;
            idx = (nidx > 13) ? 13 : nidx;
            f = TONES[octv & 7][idx];
            per = 1000000 / f;
            r.frequency_hz = 12'(f);
            r.pwm_period = 16'(per);
            r.pulse_us = 16'(volume * (per - per / 10) / 100);
            if (suffix == SUFFIX_LEGATO) begin
               on = dms; off = 0;
            end else if (suffix == SUFFIX_STACCATO) begin
               off = dms / 2; on = dms - off;
            end else begin
               off = dms / 10; on = dms - off;
            end
         end else begin
            on = 0; off = dms;
         end
         r.status = STATUS_NOTE;
         r.on_ms = 19'(on);
         r.off_ms = 19'(off);
         return r;
      endfunction

      function void note_request(req_type q);
         rsp_type r;
         bit      ends, comma;
         r = '0;
         ends = q.end_of_text;
         comma = 0;
         if (phase < PH_BEAT) begin
            header_char(q.character);
            if (ends && phase < PH_BEAT) begin
               // Tune ended inside the header.
               r.status = STATUS_HEADER; r.last = 1;
               expected_notes.push_back(r);
               phase = PH_NAME; key = 0;
               clear_note();
               return;
            end
         end else if (q.character == ",") begin
            comma = 1;
         end else begin
            note_char(q.character);
         end
         if (phase >= PH_BEAT && (comma || ends)) begin
            if (phase >= PH_ACC && phase <= PH_TAIL) begin
               r = timed_note();
               r.last = ends;
               expected_notes.push_back(r);
            end else if (ends) begin
               r.status = STATUS_END; r.last = 1;
               expected_notes.push_back(r);
            end
            clear_note();
            phase = PH_BEAT;
         end
         if (ends) begin
            phase = PH_NAME; key = 0;
            clear_note();
         end
      endfunction

      function void check_response(rsp_type a);
         rsp_type e;
         if (expected_notes.size() == 0) begin
            $error("unexpected result %h", a);
            errors++;
            return;
         end
         e = expected_notes.pop_front();
         if (a.status !== e.status) begin
            $error("status exp %0d got %0d", e.status, a.status); errors++;
         end
         if (a.frequency_hz !== e.frequency_hz) begin
            $error("frequency_hz exp %0d got %0d", e.frequency_hz, a.frequency_hz);
            errors++;
         end
         if (a.pwm_period !== e.pwm_period) begin
            $error("pwm_period exp %0d got %0d", e.pwm_period, a.pwm_period); errors++;
         end
         if (a.pulse_us !== e.pulse_us) begin
            $error("pulse_us exp %0d got %0d", e.pulse_us, a.pulse_us); errors++;
         end
         if (a.on_ms !== e.on_ms) begin
            $error("on_ms exp %0d got %0d", e.on_ms, a.on_ms); errors++;
         end
         if (a.off_ms !== e.off_ms) begin
            $error("off_ms exp %0d got %0d", e.off_ms, a.off_ms); errors++;
         end
         if (a.last !== e.last) begin
            $error("last exp %0d got %0d", e.last, a.last); errors++;
         end
      endfunction
   endclass

   logic       clock, reset;
   logic       req_valid, req_ready, rsp_valid, rsp_ready, csr_valid, csr_ready;
   req_type    req_data;
   rsp_type    rsp_data;
   logic [6:0] csr_data;

   note_scoreboard board;
   int             long_hold;   // cycles the result side must still hold off
   bit             calm;        // no idling on either side while set
   int             sent;

   ringtone_text_note_parser_unit i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   // Generous limit: the slowest legal run stays far below this.
   initial begin
      #(12 * 2_000_000);
      $display("TB_ERROR");
      $finish;
   end

   // Idle length: mostly short, a few long, none while the calm flag is set.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm) return 0;
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // Every handshake is seen here, at the rising edge, before any register of the
   // block has moved.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_data);
         if (rsp_valid && rsp_ready) board.check_response(rsp_data);
         if (csr_valid && csr_ready) board.set_volume(csr_data);
      end
   end

   // Result side flow control. A long hold requested by the stimulus is counted
   // down here so the request side keeps pushing characters meanwhile.
   initial begin
      int off_left;
      off_left = 0;
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         if (long_hold > 0) begin
            rsp_ready <= 0;
            long_hold--;
         end else if (off_left > 0) begin
            rsp_ready <= 0;
            off_left--;
         end else begin
            rsp_ready <= 1;
            if ($urandom_range(0, 3) == 0) off_left = idle_len();
         end
      end
   end

   task automatic send_char(byte unsigned c, bit ends);
      int g;
      g = idle_len();
      if (g > 0) begin
         req_valid <= 0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1;
      req_data <= '{character: c, end_of_text: ends};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent++;
   endtask

   task automatic send_tune(byte unsigned t[$]);
      foreach (t[i]) send_char(t[i], i == t.size() - 1);
      req_valid <= 0;
   endtask

   task automatic send_text(string s);
      byte unsigned t[$];
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
      send_tune(t);
   endtask

   // Waits until every predicted result has come out, then lets the back end
   // settle, since a skipped note may still be in flight behind it.
   task automatic drain();
      while (board.expected_notes.size() != 0) @(posedge clock);
      repeat (150) @(negedge clock);
   endtask

   task automatic write_volume(logic [6:0] v);
      csr_valid <= 1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   function automatic byte unsigned noise_byte();
      byte unsigned c;
      do c = $urandom_range(0, 255); while (c == ",");
      return c;
   endfunction

   function automatic void push_number(ref byte unsigned t[$], input int unsigned v);
      string s;
      s = $sformatf("%0d", v);
      for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
   endfunction

   // One random tune: a header with random keys and values, then a few notes,
   // mostly well formed, some with junk; now and then cut off early.
   function automatic void build_tune(ref byte unsigned t[$]);
      string       letters;
      byte unsigned keys [4];
      int          n;
      letters = "abcdefgABCDEFG";
      keys = '{"d", "o", "b", "x"};
      t.delete();
      repeat ($urandom_range(0, 4))
         t.push_back(($urandom_range(0, 9) == 0) ? noise_byte() : $urandom_range("a", "z"));
      t.push_back(":");
      n = $urandom_range(0, 3);
      for (int k = 0; k < n; k++) begin
         int unsigned v;
         case ($urandom_range(0, 5))
            0: v = 0;
            1: v = $urandom_range(0, 99999);
            2: v = $urandom_range(1, 9);
            default: v = $urandom_range(1, 300);
         endcase
         if (k > 0) t.push_back(",");
         t.push_back(keys[$urandom_range(0, 3)]);
         t.push_back("=");
         push_number(t, v);
      end
      t.push_back(":");
      repeat ($urandom_range(1, 7)) begin
         if ($urandom_range(0, 19) != 0) begin
            int r;
            r = $urandom_range(0, 9);
            if (r < 3) push_number(t, $urandom_range(0, 5) == 0 ? $urandom_range(0, 400)
                                                              : 1 << $urandom_range(0, 5));
            r = $urandom_range(0, 19);
            if (r < 15) t.push_back(letters[$urandom_range(0, 13)]);
            else if (r < 18) t.push_back("p");
            else t.push_back(noise_byte());
            if ($urandom_range(0, 2) == 0) t.push_back($urandom_range(0, 1) ? "#" : "b");
            if ($urandom_range(0, 1) == 0) t.push_back("0" + $urandom_range(0, 9));
            if ($urandom_range(0, 2) == 0) t.push_back(".");
            if ($urandom_range(0, 2) == 0) t.push_back($urandom_range(0, 1) ? "l" : "s");
            if ($urandom_range(0, 9) == 0) t.push_back(noise_byte());
         end
         t.push_back(",");
      end
      // Usually drop the final comma so the note is closed by the end mark.
      if ($urandom_range(0, 3) != 0) void'(t.pop_back());
      if ($urandom_range(0, 9) == 0) t = t[0:$urandom_range(0, t.size() - 1)];
   endfunction

   initial begin
      byte unsigned tune[$];
      logic [6:0]   vols [4];
      int           tunes;
      vols = '{7'd0, 7'd127, 7'd1, 7'd100};
      board = new();
      reset = 1;
      req_valid = 0; req_data = '0; csr_valid = 0; csr_data = '0;
      long_hold = 0; calm = 0; sent = 0; tunes = 0;
      repeat (11) @(negedge clock);
      reset = 0;

      // Directed: zero header values ignored, octave clamp, sharps and flats
      // including a flat of a, dotted, legato and staccato, rests with junk,
      // invalid and empty notes, then a tune cut off inside its header.
      write_volume(7'd0);
      send_text("t:d=0,o=9,b=0:c,32c#.l,pb4.s,ab,Eb8,h,,G9s,2d0.x,p");
      drain();
      write_volume(7'd127);
      send_text("\377:x=5,b=1,d=1:1c.");
      send_text("ab:d=4");
      send_text("z:b=99999,d=999:64f,c");
      drain();

      // Random tunes. One of them runs while the result side holds off long
      // enough for the block to back up onto its input.
      while (sent < 1250) begin
         if (tunes % 8 == 0) begin
            drain();
            write_volume(tunes < 32 ? vols[tunes / 8] : 7'($urandom_range(0, 127)));
         end
         calm = ($urandom_range(0, 4) == 0);
         if (tunes == 5) long_hold = 800;
         build_tune(tune);
         send_tune(tune);
         tunes++;
      end

      while (board.expected_notes.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (board.errors == 0 && board.expected_notes.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
